// ----- rtl/dcrp_pkg.sv -----
// shared types, codes and command table of the dsp command/response port
package dcrp_pkg;

    localparam int REPLY_DEPTH_DEFAULT = 15;
    localparam logic [15:0] DSP_VERSION_RESET = 16'h0105;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [1:0] PORT_RESET   = 2'd0;
    localparam logic [1:0] PORT_DATA    = 2'd1;
    localparam logic [1:0] PORT_COMMAND = 2'd2;
    localparam logic [1:0] PORT_STATUS  = 2'd3;

    localparam logic [7:0] CMD_SPEAKER_ON  = 8'hD1;
    localparam logic [7:0] CMD_SPEAKER_OFF = 8'hD3;
    localparam logic [7:0] CMD_SPEAKER_STS = 8'hD8;
    localparam logic [7:0] CMD_INVERT_ID   = 8'hE0;
    localparam logic [7:0] CMD_VERSION     = 8'hE1;
    localparam logic [7:0] CMD_WRITE_TEST  = 8'hE4;
    localparam logic [7:0] CMD_READ_TEST   = 8'hE8;
    localparam logic [7:0] CMD_IRQ5        = 8'hF2;
    localparam logic [7:0] CMD_F8          = 8'hF8;

    localparam logic [7:0] RESET_REPLY  = 8'hAA;
    localparam logic [7:0] STATUS_READY = 8'h80;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;

    typedef struct packed {
        logic       mode;
        logic [1:0] port_select;
        logic       odd_byte;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } rsp_t;

    // queue control from the decode logic for one step
    typedef struct packed {
        logic       pop;
        logic       push0;
        logic       push1;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } queue_ctrl_t;

    // command length including the command byte, 0 for undefined codes
    function automatic logic [1:0] cmd_length(input logic [7:0] c);
        logic [1:0] len;
        case (c)
            CMD_SPEAKER_ON, CMD_SPEAKER_OFF, CMD_SPEAKER_STS, CMD_VERSION,
            CMD_READ_TEST, CMD_IRQ5, CMD_F8: len = 2'd1;
            CMD_INVERT_ID, CMD_WRITE_TEST:   len = 2'd2;
            default:                         len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/dcrp_queue.sv -----
// reply queue: shift line of byte cells with head at entry 0
module dcrp_queue #(
    parameter int DEPTH = dcrp_pkg::REPLY_DEPTH_DEFAULT,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dcrp_pkg::queue_ctrl_t ctrl,
    output logic [7:0]            head,
    output logic [CW-1:0]         count
);
    import dcrp_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [7:0]    q_reg [DEPTH];
    logic [7:0]    q_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] slot1;
    logic          room0;
    logic          room1;

    always_comb
    begin
        slot1 = count_reg + CW'(1);
        room0 = ctrl.push0 && (count_reg < DEPTH_C);
        room1 = ctrl.push1 && room0 && (slot1 < DEPTH_C);
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (ctrl.pop)
        begin
            // cells above the count hold zero, and an empty pop changes nothing
            if (count_reg != '0)
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    q_next[i] = q_reg[i + 1];
                end
                q_next[DEPTH - 1] = BYTE_ZERO;
                count_next = count_reg - CW'(1);
            end
        end
        else
        begin
            // full queue drops the byte
            for (int i = 0; i < DEPTH; i++)
            begin
                if (room0 && count_reg == CW'(i))
                begin
                    q_next[i] = ctrl.byte0;
                end
                if (room1 && slot1 == CW'(i))
                begin
                    q_next[i] = ctrl.byte1;
                end
            end
            count_next = count_reg + CW'(room0) + CW'(room1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                q_reg[i] <= BYTE_ZERO;
            end
        end
        else if (step)
        begin
            count_reg <= count_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    assign head  = q_reg[0];
    assign count = count_reg;

endmodule

// ----- rtl/dcrp_core.sv -----
// access decode, command collector and dsp state for one bus transfer
module dcrp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dcrp_pkg::req_t        item,
    input  logic [7:0]            head,
    input  logic                  empty,
    input  logic [15:0]           dsp_version,
    output dcrp_pkg::queue_ctrl_t qctrl,
    output dcrp_pkg::rsp_t        result
);
    import dcrp_pkg::*;

    logic [7:0] latch_reg;
    logic [7:0] latch_next;
    logic [7:0] first_reg;
    logic [7:0] first_next;
    logic       pending_reg;
    logic       pending_next;
    logic       speaker_reg;
    logic       speaker_next;
    logic [7:0] scratch_reg;
    logic [7:0] scratch_next;

    logic       wr;
    logic [7:0] cmd;
    logic [1:0] len;
    logic       exec;

    always_comb
    begin
        wr = (item.mode == MODE_WRITE) && !item.odd_byte;
        len = cmd_length(item.write_data);
        // with a byte pending, the stored byte is the command and this one its parameter
        cmd = pending_reg ? first_reg : item.write_data;
        exec = pending_reg || (len == 2'd1);

        latch_next   = latch_reg;
        first_next   = first_reg;
        pending_next = pending_reg;
        speaker_next = speaker_reg;
        scratch_next = scratch_reg;

        qctrl  = '0;
        result = '0;

        if (item.mode == MODE_READ)
        begin
            if (item.odd_byte)
            begin
                result.read_data = BYTE_ONES;
            end
            else
            begin
                case (item.port_select)
                    PORT_RESET:   result.read_data = BYTE_ONES;
                    PORT_DATA:
                    begin
                        result.read_data = head;
                        qctrl.pop = 1'b1;
                    end
                    PORT_COMMAND: result.read_data = BYTE_ZERO;
                    default:      result.read_data = empty ? BYTE_ZERO : STATUS_READY;
                endcase
            end
        end
        else if (wr && item.port_select == PORT_RESET)
        begin
            if (item.write_data == BYTE_ZERO && latch_reg == 8'd1)
            begin
                qctrl.push0 = 1'b1;
                qctrl.byte0 = RESET_REPLY;
            end
            latch_next = item.write_data;
        end
        else if (wr && item.port_select == PORT_COMMAND)
        begin
            if (pending_reg)
            begin
                pending_next = 1'b0;
            end
            else if (len == 2'd2)
            begin
                pending_next = 1'b1;
                first_next   = item.write_data;
            end
            if (exec)
            begin
                case (cmd)
                    CMD_SPEAKER_ON:  speaker_next = 1'b1;
                    CMD_SPEAKER_OFF: speaker_next = 1'b0;
                    CMD_SPEAKER_STS:
                    begin
                        qctrl.push0 = 1'b1;
                        qctrl.byte0 = speaker_reg ? BYTE_ONES : BYTE_ZERO;
                    end
                    CMD_INVERT_ID:
                    begin
                        qctrl.push0 = 1'b1;
                        qctrl.byte0 = item.write_data ^ BYTE_ONES;
                    end
                    CMD_VERSION:
                    begin
                        qctrl.push0 = 1'b1;
                        qctrl.push1 = 1'b1;
                        qctrl.byte0 = dsp_version[15:8];
                        qctrl.byte1 = dsp_version[7:0];
                    end
                    CMD_WRITE_TEST:  scratch_next = item.write_data;
                    CMD_READ_TEST:
                    begin
                        qctrl.push0 = 1'b1;
                        qctrl.byte0 = scratch_reg;
                    end
                    CMD_IRQ5:        result.irq_pulse = 1'b1;
                    CMD_F8:
                    begin
                        qctrl.push0 = 1'b1;
                        qctrl.byte0 = BYTE_ZERO;
                    end
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            first_reg   <= '0;
            pending_reg <= 1'b0;
            speaker_reg <= 1'b0;
            scratch_reg <= '0;
        end
        else if (step)
        begin
            latch_reg   <= latch_next;
            first_reg   <= first_next;
            pending_reg <= pending_next;
            speaker_reg <= speaker_next;
            scratch_reg <= scratch_next;
        end
    end

endmodule

// ----- rtl/dsp_command_response_port_unit.sv -----
// top level of the dsp command/response port: input register, decode, queue, result register
//
//  channel   direction  handshake                 payload
//  req       in         req_valid / req_ready     req (mode, port_select, odd_byte, write_data)
//  rsp       out        rsp_valid / rsp_ready     rsp (read_data, irq_pulse)
//  cfg       in         cfg_write_en              cfg_write_data (dsp version word)
//
// one transfer per cycle sustained while rsp_ready stays high; an item passes through the
// input register and then the result register on its way from accept to result
// all core and queue state updates happen as an item moves from the input register to the result register
// rst_n clears control state and the reply queue at once; no clearing pass
// a stalled rsp holds the result register, and req stalls while the input register is full and cannot advance
module dsp_command_response_port_unit #(
    parameter int REPLY_DEPTH = dcrp_pkg::REPLY_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dcrp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dcrp_pkg::rsp_t rsp,
    input  logic           cfg_write_en,
    input  logic [15:0]    cfg_write_data
);
    import dcrp_pkg::*;

    localparam int CW = $clog2(REPLY_DEPTH + 1);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    req_t        s1_item_reg;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_t        rsp_reg;
    logic [15:0] version_reg;

    logic          advance;
    queue_ctrl_t   qctrl;
    rsp_t          result;
    logic [7:0]    head;
    logic [CW-1:0] count;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            version_reg   <= DSP_VERSION_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write_en)
            begin
                version_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    dcrp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (s1_item_reg),
        .head        (head),
        .empty       (count == '0),
        .dsp_version (version_reg),
        .qctrl       (qctrl),
        .result      (result)
    );

    dcrp_queue #(
        .DEPTH (REPLY_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ctrl  (qctrl),
        .head  (head),
        .count (count)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(REPLY_DEPTH))
        else $error("reply count above depth");

    // a data port read on an empty queue leaves it empty and returns zero
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        advance && qctrl.pop && count == '0 |=> count == '0 && rsp.read_data == BYTE_ZERO)
        else $error("empty pop changed queue or returned data");

    // req stalls only with both registers occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("req stalled with room in the pipeline");

    // read status reflects queue occupancy at the transfer
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.mode == MODE_READ && !s1_item_reg.odd_byte &&
        s1_item_reg.port_select == PORT_STATUS && count != '0
        |=> rsp.read_data == STATUS_READY)
        else $error("read status missed waiting data");

endmodule

// ----- dv/tb_dsp_command_response_port_unit.sv -----
// testbench for the dsp command/response port: random bus accesses checked against a shadow model
`timescale 1ns / 100ps

module tb_dsp_command_response_port_unit;
    import dcrp_pkg::*;

    localparam int REPLY_DEPTH = REPLY_DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_SHOWN   = 10;

    localparam logic [7:0] RESET_ARM     = 8'h01;
    localparam logic [7:0] RESET_FIRE    = 8'h00;
    localparam logic [7:0] CMD_UNDEFINED = 8'h00;

    // shadow of the port state plus the results still owed by the block
    class port_shadow;
        logic [7:0]  latch_byte;
        logic [7:0]  cmd_bytes [2];
        int unsigned cmd_fill;
        logic [7:0]  replies [$];
        bit          ready_flag;
        bit          spk_enabled;
        logic [7:0]  test_byte;
        logic [15:0] version_word;
        rsp_t        owed_results [$];
        int unsigned mismatches;

        function new();
            latch_byte   = BYTE_ZERO;
            cmd_bytes[0] = BYTE_ZERO;
            cmd_bytes[1] = BYTE_ZERO;
            cmd_fill     = 0;
            ready_flag   = 1'b0;
            spk_enabled  = 1'b0;
            test_byte    = BYTE_ZERO;
            version_word = DSP_VERSION_RESET;
            mismatches   = 0;
        endfunction

        function void set_version(input logic [15:0] word);
            version_word = word;
        endfunction

        function int unsigned span_of(input logic [7:0] code);
            case (code)
                CMD_SPEAKER_ON, CMD_SPEAKER_OFF, CMD_SPEAKER_STS, CMD_VERSION,
                CMD_READ_TEST, CMD_IRQ5, CMD_F8:
                    return 1;
                CMD_INVERT_ID, CMD_WRITE_TEST:
                    return 2;
                default:
                    return 0;
            endcase
        endfunction

        // flag is set even when the byte is dropped
        function void queue_reply(input logic [7:0] b);
            ready_flag = 1'b1;
            if (replies.size() < REPLY_DEPTH)
                replies.push_back(b);
        endfunction

        function logic [7:0] take_reply();
            logic [7:0] b;
            b = BYTE_ZERO;
            if (replies.size() > 0)
                b = replies.pop_front();
            if (replies.size() == 0)
                ready_flag = 1'b0;
            return b;
        endfunction

        function bit run_command(input logic [7:0] b);
            logic [7:0]  code;
            int unsigned span;
            bit          irq;
            irq = 1'b0;
            if (cmd_fill < 2) begin
                cmd_bytes[cmd_fill] = b;
                cmd_fill++;
            end
            code = cmd_bytes[0];
            span = span_of(code);
            // unknown code clears the collector
            if (span == 0) begin
                cmd_fill = 0;
                return 1'b0;
            end
            if (cmd_fill != span)
                return 1'b0;
            case (code)
                CMD_SPEAKER_ON:  spk_enabled = 1'b1;
                CMD_SPEAKER_OFF: spk_enabled = 1'b0;
                CMD_SPEAKER_STS: queue_reply(spk_enabled ? BYTE_ONES : BYTE_ZERO);
                CMD_INVERT_ID:   queue_reply(cmd_bytes[1] ^ BYTE_ONES);
                CMD_VERSION:
                begin
                    queue_reply(version_word[15:8]);
                    queue_reply(version_word[7:0]);
                end
                CMD_WRITE_TEST:  test_byte = cmd_bytes[1];
                CMD_READ_TEST:   queue_reply(test_byte);
                CMD_IRQ5:        irq = 1'b1;
                CMD_F8:          queue_reply(BYTE_ZERO);
                default:         ;
            endcase
            cmd_fill = 0;
            return irq;
        endfunction

        function void note_access(input req_t a);
            rsp_t r;
            r.read_data = BYTE_ZERO;
            r.irq_pulse = 1'b0;
            if (a.mode == MODE_READ) begin
                if (a.odd_byte) begin
                    r.read_data = BYTE_ONES;
                end
                else begin
                    case (a.port_select)
                        PORT_RESET:   r.read_data = BYTE_ONES;
                        PORT_DATA:    r.read_data = take_reply();
                        PORT_COMMAND: r.read_data = BYTE_ZERO;
                        default:      r.read_data = ready_flag ? STATUS_READY : BYTE_ZERO;
                    endcase
                end
            end
            else if (!a.odd_byte) begin
                if (a.port_select == PORT_RESET) begin
                    if (a.write_data == RESET_FIRE && latch_byte == RESET_ARM)
                        queue_reply(RESET_REPLY);
                    latch_byte = a.write_data;
                end
                else if (a.port_select == PORT_COMMAND) begin
                    r.irq_pulse = run_command(a.write_data);
                end
            end
            owed_results.push_back(r);
        endfunction

        function void check_result(input rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: read_data %h irq_pulse %b",
                             got.read_data, got.irq_pulse);
                return;
            end
            want = owed_results.pop_front();
            if (got.read_data !== want.read_data || got.irq_pulse !== want.irq_pulse) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("mismatch: read_data exp %h got %h, irq_pulse exp %b got %b",
                             want.read_data, got.read_data, want.irq_pulse, got.irq_pulse);
            end
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    port_shadow  shadow;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned accesses_sent = 0;

    dsp_command_response_port_unit #(
        .REPLY_DEPTH(REPLY_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    always #5 clk = ~clk;

    // one bus access; valid stays up across back-to-back transfers
    task automatic bus_access(input logic m, input logic [1:0] p, input logic o,
                              input logic [7:0] d);
        req_t item;
        int   gap;
        item.mode        = m;
        item.port_select = p;
        item.odd_byte    = o;
        item.write_data  = d;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        shadow.note_access(item);
        accesses_sent++;
    endtask

    task automatic settle_block();
        req_valid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_version(input logic [15:0] word);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= word;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        shadow.set_version(word);
    endtask

    task automatic random_sequence();
        int         kind;
        int         n;
        logic [7:0] code;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            case ($urandom_range(0, 8))
                0:       code = CMD_SPEAKER_ON;
                1:       code = CMD_SPEAKER_OFF;
                2:       code = CMD_SPEAKER_STS;
                3:       code = CMD_INVERT_ID;
                4:       code = CMD_VERSION;
                5:       code = CMD_WRITE_TEST;
                6:       code = CMD_READ_TEST;
                7:       code = CMD_IRQ5;
                default: code = CMD_F8;
            endcase
            bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, code);
            if (shadow.span_of(code) == 2) begin
                // a stray read between command and parameter must not disturb the collector
                if ($urandom_range(0, 7) == 0)
                    bus_access(MODE_READ, 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 8'h00);
                bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 50) begin
            do
                code = 8'($urandom_range(0, 255));
            while (shadow.span_of(code) != 0);
            bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, code);
        end
        else if (kind < 75) begin
            n = $urandom_range(1, 3);
            repeat (n) bus_access(MODE_READ, PORT_DATA, 1'b0, 8'($urandom_range(0, 255)));
        end
        else if (kind < 82) begin
            bus_access(MODE_READ, PORT_STATUS, 1'b0, 8'($urandom_range(0, 255)));
        end
        else if (kind < 87) begin
            bus_access(MODE_WRITE, PORT_RESET, 1'b0, RESET_ARM);
            bus_access(MODE_WRITE, PORT_RESET, 1'b0,
                       ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : RESET_FIRE);
        end
        else if (kind < 98) begin
            bus_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        else begin
            // burst of version requests, often enough to overflow the reply queue
            n = $urandom_range(6, 10);
            repeat (n) bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_VERSION);
            bus_access(MODE_READ, PORT_STATUS, 1'b0, 8'h00);
            repeat (REPLY_DEPTH + 1) bus_access(MODE_READ, PORT_DATA, 1'b0, 8'h00);
            bus_access(MODE_READ, PORT_STATUS, 1'b0, 8'h00);
        end
    endtask

    initial begin : result_sink
        int stall;
        rsp_ready = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                stall = idle_on ? $urandom_range(0, 11) : 0;
                if (stall > 0) begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (rsp_valid !== 1'b1)
                @(posedge clk);
            shadow.check_result(rsp);
        end
    end

    initial begin : watchdog
        #(3_000_000);
        $display("tb_dsp_command_response_port_unit: errors");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] word;
        shadow         = new();
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain reads, odd addresses, a reset arm and fire, and ignored writes
        bus_access(MODE_READ,  PORT_RESET,   1'b0, 8'h00);
        bus_access(MODE_READ,  PORT_DATA,    1'b0, 8'hFF);
        bus_access(MODE_READ,  PORT_COMMAND, 1'b0, 8'h00);
        bus_access(MODE_READ,  PORT_STATUS,  1'b0, 8'h00);
        bus_access(MODE_READ,  PORT_DATA,    1'b1, 8'h00);
        bus_access(MODE_WRITE, PORT_RESET,   1'b1, RESET_ARM);
        bus_access(MODE_WRITE, PORT_RESET,   1'b0, RESET_ARM);
        bus_access(MODE_WRITE, PORT_RESET,   1'b0, RESET_FIRE);
        bus_access(MODE_WRITE, PORT_DATA,    1'b0, 8'h55);
        bus_access(MODE_WRITE, PORT_STATUS,  1'b0, 8'hFF);
        // every command at least once, then an unknown code
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_SPEAKER_ON);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_SPEAKER_STS);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_SPEAKER_OFF);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_SPEAKER_STS);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_INVERT_ID);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, 8'h00);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_VERSION);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_WRITE_TEST);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, 8'hFF);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_READ_TEST);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_IRQ5);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_F8);
        bus_access(MODE_WRITE, PORT_COMMAND, 1'b0, CMD_UNDEFINED);
        bus_access(MODE_READ,  PORT_STATUS,  1'b0, 8'h00);
        repeat (4) bus_access(MODE_READ, PORT_DATA, 1'b0, 8'h00);
        settle_block();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       word = 16'h0000;
                1:       word = 16'hFFFF;
                2:       word = 16'($urandom_range(0, 65535));
                default: word = DSP_VERSION_RESET;
            endcase
            write_version(word);
            // phase 1 runs with no idling on either side
            idle_on = (phase != 1);
            if (phase == 2)
                hold_request = 1'b1;
            while (accesses_sent < 30 + (phase + 1) * 255)
                random_sequence();
            settle_block();
        end

        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("tb_dsp_command_response_port_unit: clean");
        else
            $display("tb_dsp_command_response_port_unit: errors");
        $finish;
    end

endmodule
